// ===== src/vcp_pkg.sv =====
package vcp_pkg;

	localparam int COORD_W   = 32;
	localparam int FRAC_BITS = 16;
	localparam int DIST_W    = COORD_W + 2;

	localparam logic [1:0] KIND_FIXED   = 2'd0;
	localparam logic [1:0] KIND_LINE    = 2'd1;
	localparam logic [1:0] KIND_PLANE   = 2'd2;
	localparam logic [1:0] KIND_UNKNOWN = 2'd3;

	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_UNKNOWN = 2'd1;
	localparam logic [1:0] STAT_ZERO    = 2'd2;
	localparam logic [1:0] STAT_SAT     = 2'd3;

	typedef struct packed {
		logic [1:0]                kind;
		logic signed [COORD_W-1:0] coef_a;
		logic signed [COORD_W-1:0] coef_b;
		logic signed [COORD_W-1:0] coef_c;
		logic signed [COORD_W-1:0] coef_d;
		logic signed [COORD_W-1:0] coef_e;
		logic signed [COORD_W-1:0] coef_f;
		logic signed [COORD_W-1:0] point_x;
		logic signed [COORD_W-1:0] point_y;
		logic signed [COORD_W-1:0] point_z;
	} in_item_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] near_x;
		logic signed [COORD_W-1:0] near_y;
		logic signed [COORD_W-1:0] near_z;
		logic [DIST_W-1:0]         distance;
		logic [1:0]                status;
	} out_item_t;

endpackage

// ===== src/vertex_constraint_projector.sv =====
// Channel   Ports                    Transfer
// -------   ----------------------   ------------------------------------------
// request   start, busy, item        start high and busy low at a clock edge
// result    done, result             done high for one cycle, always taken
//
// Fully pipelined: one transaction can enter every cycle; busy stays low.
// The path holds QW = max(2W, W+F) + 3 restoring divider stages (one quotient
// bit each) and RB = W + 1 square root stages (one root bit each).
// arst_n clears only the valid bits; data registers are not reset.
// The receiver cannot stall, so the pipeline advances on every clock.
module vertex_constraint_projector #(
	parameter int FRAC_BITS = vcp_pkg::FRAC_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  vcp_pkg::in_item_t  item,
	output logic               busy,
	output logic               done,
	output vcp_pkg::out_item_t result
);

	localparam int W    = vcp_pkg::COORD_W;
	localparam int F    = FRAC_BITS;
	localparam int NW   = ((W + F > 2 * W) ? W + F : 2 * W) + 2;
	localparam int LOW  = (NW + 1) / 2;
	localparam int HIW  = NW - LOW;
	localparam int PW   = W + NW;
	localparam int QW   = NW + 1;
	localparam int DW   = 2 * W + 1;
	localparam int VW   = QW + 2;
	localparam int RB   = W + 1;

	typedef struct packed {
		logic [2:0][W-1:0] base;
		logic [2:0][W-1:0] pt;
		logic              use_t;
		logic [1:0]        status;
	} side_t;

	typedef struct packed {
		side_t              side;
		logic [2:0]         psign;
		logic [DW-1:0]      den;
		logic [2:0][DW-1:0] rem;
		logic [2:0][QW-1:0] bits;
	} dv_t;

	typedef struct packed {
		logic [2:0][W-1:0] res;
		logic [1:0]        status;
		logic [RB:0]       rem;
		logic [RB-1:0]     root;
		logic [2*RB-1:0]   rad;
	} sr_t;

	assign busy = 1'b0;

	// ---------------- stage 1: per-axis products
	logic signed [W-1:0]   cf [6];
	logic signed [W-1:0]   pt [3];
	logic signed [W-1:0]   dir_c [3];
	logic signed [W-1:0]   base_c [3];
	logic signed [W:0]     m_c [3];
	logic signed [2*W:0]   prod_c [3];
	logic signed [2*W-1:0] sq_c [3];
	side_t                 side_c;

	assign cf[0] = item.coef_a;
	assign cf[1] = item.coef_b;
	assign cf[2] = item.coef_c;
	assign cf[3] = item.coef_d;
	assign cf[4] = item.coef_e;
	assign cf[5] = item.coef_f;
	assign pt[0] = item.point_x;
	assign pt[1] = item.point_y;
	assign pt[2] = item.point_z;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (item.kind == vcp_pkg::KIND_LINE) begin
				dir_c[i]  = cf[2*i];
				base_c[i] = cf[2*i+1];
				m_c[i]    = (W+1)'(pt[i]) - (W+1)'(cf[2*i+1]);
			end else begin
				dir_c[i]  = cf[i];
				base_c[i] = (item.kind == vcp_pkg::KIND_PLANE) ? pt[i] : cf[i];
				m_c[i]    = (W+1)'(pt[i]);
			end
			prod_c[i] = (2*W+1)'(dir_c[i]) * (2*W+1)'(m_c[i]);
			sq_c[i]   = (2*W)'(dir_c[i]) * (2*W)'(dir_c[i]);
			side_c.base[i] = base_c[i];
			side_c.pt[i]   = pt[i];
		end
		side_c.use_t  = (item.kind == vcp_pkg::KIND_LINE) ||
				(item.kind == vcp_pkg::KIND_PLANE);
		side_c.status = (item.kind == vcp_pkg::KIND_UNKNOWN) ?
				vcp_pkg::STAT_UNKNOWN : vcp_pkg::STAT_OK;
	end

	logic signed [2*W:0] prod_s1 [3];
	logic [2*W-1:0]      sq_s1 [3];
	logic signed [W-1:0] dir_s1 [3];
	logic signed [W-1:0] dterm_s1;
	logic                plane_s1;
	side_t               side_s1;
	logic                v_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			prod_s1[i] <= prod_c[i];
			sq_s1[i]   <= sq_c[i];
			dir_s1[i]  <= dir_c[i];
		end
		dterm_s1 <= item.coef_d;
		plane_s1 <= (item.kind == vcp_pkg::KIND_PLANE);
		side_s1  <= side_c;
	end

	// ---------------- stage 2: dot product, squared norm, magnitudes
	logic signed [NW-1:0] sum_c;
	logic signed [NW-1:0] n_c;
	logic [2*W-1:0]       q_c;
	side_t                side2_c;

	always_comb begin
		sum_c = NW'(prod_s1[0]) + NW'(prod_s1[1]) + NW'(prod_s1[2]);
		// plane: n = d*2^F - a.x
		n_c   = plane_s1 ? ((NW'(dterm_s1) <<< F) - sum_c) : sum_c;
		q_c   = sq_s1[0] + sq_s1[1] + sq_s1[2];
		side2_c = side_s1;
		if (side_s1.use_t && q_c == '0) begin
			side2_c.status = vcp_pkg::STAT_ZERO;
		end
	end

	logic [NW-1:0]  nmag_s2;
	logic [2*W-1:0] q_s2;
	logic [W-1:0]   dmag_s2 [3];
	logic [2:0]     psign_s2;
	side_t          side_s2;
	logic           v_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		nmag_s2 <= n_c[NW-1] ? NW'(-n_c) : NW'(n_c);
		q_s2    <= q_c;
		for (int i = 0; i < 3; i++) begin
			dmag_s2[i]  <= dir_s1[i][W-1] ? W'(-dir_s1[i]) : W'(dir_s1[i]);
			psign_s2[i] <= dir_s1[i][W-1] ^ n_c[NW-1];
		end
		side_s2 <= side2_c;
	end

	// ---------------- stage 3: partial products of |dir| * |n|
	logic [W+LOW-1:0] pl_s3 [3];
	logic [W+HIW-1:0] ph_s3 [3];
	logic [2*W-1:0]   q_s3;
	logic [2:0]       psign_s3;
	side_t            side_s3;
	logic             v_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			pl_s3[i] <= (W+LOW)'(dmag_s2[i]) * (W+LOW)'(nmag_s2[LOW-1:0]);
			ph_s3[i] <= (W+HIW)'(dmag_s2[i]) * (W+HIW)'(nmag_s2[NW-1:LOW]);
		end
		q_s3     <= q_s2;
		psign_s3 <= psign_s2;
		side_s3  <= side_s2;
	end

	// ---------------- stage 4: rounding numerator 2|p| + q, denominator 2q
	logic [PW+1:0] num_s4 [3];
	logic [DW-1:0] den_s4;
	logic [2:0]    psign_s4;
	side_t         side_s4;
	logic          v_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			num_s4[i] <= (((PW+2)'(ph_s3[i]) << LOW) + (PW+2)'(pl_s3[i]) << 1) +
					(PW+2)'(q_s3);
		end
		den_s4   <= {q_s3, 1'b0};
		psign_s4 <= psign_s3;
		side_s4  <= side_s3;
	end

	// ---------------- restoring divider, one quotient bit per stage
	// the quotient is known to fit QW bits, so the top numerator bits
	// preload the remainder
	dv_t  dv_init;
	dv_t  dv_sd [QW];
	logic dv_v_sd [QW];

	always_comb begin
		dv_init.side  = side_s4;
		dv_init.psign = psign_s4;
		dv_init.den   = den_s4;
		for (int i = 0; i < 3; i++) begin
			dv_init.rem[i]  = DW'(num_s4[i][PW+1:QW]);
			dv_init.bits[i] = num_s4[i][QW-1:0];
		end
	end

	for (genvar j = 0; j < QW; j++) begin : g_div
		dv_t  cur;
		dv_t  nxt;
		logic vin;

		if (j == 0) begin : g_first
			assign cur = dv_init;
			assign vin = v_s4;
		end else begin : g_next
			assign cur = dv_sd[j-1];
			assign vin = dv_v_sd[j-1];
		end

		always_comb begin
			logic [DW:0] trial;
			logic        ge;
			nxt = cur;
			for (int i = 0; i < 3; i++) begin
				trial = {cur.rem[i], cur.bits[i][QW-1]};
				ge    = trial >= {1'b0, cur.den};
				nxt.rem[i]  = ge ? DW'(trial - {1'b0, cur.den}) : trial[DW-1:0];
				nxt.bits[i] = {cur.bits[i][QW-2:0], ge};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_sd[j] <= 1'b0;
			end else begin
				dv_v_sd[j] <= vin;
			end
		end

		always_ff @(posedge clk) begin
			dv_sd[j] <= nxt;
		end
	end

	// ---------------- stage 5: add to base, clamp, status
	localparam logic signed [VW-1:0] VMAX = {{(VW-W+1){1'b0}}, {(W-1){1'b1}}};
	localparam logic signed [VW-1:0] VMIN = {{(VW-W+1){1'b1}}, {(W-1){1'b0}}};

	dv_t               dv_last;
	logic signed [VW-1:0] vb_c [3];
	logic signed [VW-1:0] vq_c [3];
	logic signed [VW-1:0] v_c  [3];
	logic [2:0][W-1:0] res_c;
	logic              sat_c;
	logic [1:0]        stat_c;

	assign dv_last = dv_sd[QW-1];

	always_comb begin
		sat_c = 1'b0;
		for (int i = 0; i < 3; i++) begin
			vb_c[i] = VW'($signed(dv_last.side.base[i]));
			vq_c[i] = {2'b00, dv_last.bits[i]};
			if (!dv_last.side.use_t) begin
				v_c[i] = vb_c[i];
			end else if (dv_last.psign[i]) begin
				v_c[i] = vb_c[i] - vq_c[i];
			end else begin
				v_c[i] = vb_c[i] + vq_c[i];
			end
			if (dv_last.side.status != vcp_pkg::STAT_OK) begin
				res_c[i] = dv_last.side.pt[i];
			end else if (v_c[i] > VMAX) begin
				res_c[i] = VMAX[W-1:0];
				sat_c    = 1'b1;
			end else if (v_c[i] < VMIN) begin
				res_c[i] = VMIN[W-1:0];
				sat_c    = 1'b1;
			end else begin
				res_c[i] = v_c[i][W-1:0];
			end
		end
		if (dv_last.side.status != vcp_pkg::STAT_OK) begin
			stat_c = dv_last.side.status;
		end else begin
			stat_c = sat_c ? vcp_pkg::STAT_SAT : vcp_pkg::STAT_OK;
		end
	end

	logic [2:0][W-1:0] res_s5;
	logic [2:0][W-1:0] pt_s5;
	logic [1:0]        stat_s5;
	logic              v_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else begin
			v_s5 <= dv_v_sd[QW-1];
		end
	end

	always_ff @(posedge clk) begin
		res_s5  <= res_c;
		pt_s5   <= dv_last.side.pt;
		stat_s5 <= stat_c;
	end

	// ---------------- stage 6: squared offsets
	logic signed [W:0]     e_c  [3];
	logic signed [2*W+1:0] e2_c [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			e_c[i]  = (W+1)'($signed(pt_s5[i])) - (W+1)'($signed(res_s5[i]));
			e2_c[i] = (2*W+2)'(e_c[i]) * (2*W+2)'(e_c[i]);
		end
	end

	logic [2*W-1:0]    e2_s6 [3];
	logic [2:0][W-1:0] res_s6;
	logic [1:0]        stat_s6;
	logic              v_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			e2_s6[i] <= e2_c[i][2*W-1:0];
		end
		res_s6  <= res_s5;
		stat_s6 <= stat_s5;
	end

	// ---------------- stage 7: radicand
	logic [2*RB-1:0]   rad_s7;
	logic [2:0][W-1:0] res_s7;
	logic [1:0]        stat_s7;
	logic              v_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else begin
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		rad_s7  <= (2*RB)'(e2_s6[0]) + (2*RB)'(e2_s6[1]) + (2*RB)'(e2_s6[2]);
		res_s7  <= res_s6;
		stat_s7 <= stat_s6;
	end

	// ---------------- digit-by-digit square root, one root bit per stage
	sr_t  sr_init;
	sr_t  sr_sr [RB];
	logic sr_v_sr [RB];

	always_comb begin
		sr_init.res    = res_s7;
		sr_init.status = stat_s7;
		sr_init.rem    = '0;
		sr_init.root   = '0;
		sr_init.rad    = rad_s7;
	end

	for (genvar k = 0; k < RB; k++) begin : g_sqrt
		sr_t  cur;
		sr_t  nxt;
		logic vin;

		if (k == 0) begin : g_first
			assign cur = sr_init;
			assign vin = v_s7;
		end else begin : g_next
			assign cur = sr_sr[k-1];
			assign vin = sr_v_sr[k-1];
		end

		always_comb begin
			logic [RB+2:0] remsh;
			logic [RB+2:0] trial;
			logic          ge;
			nxt   = cur;
			remsh = {cur.rem, cur.rad[2*RB-1:2*RB-2]};
			trial = {1'b0, cur.root, 2'b01};
			ge    = remsh >= trial;
			nxt.rem  = ge ? (RB+1)'(remsh - trial) : remsh[RB:0];
			nxt.root = {cur.root[RB-2:0], ge};
			nxt.rad  = {cur.rad[2*RB-3:0], 2'b00};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sr_v_sr[k] <= 1'b0;
			end else begin
				sr_v_sr[k] <= vin;
			end
		end

		always_ff @(posedge clk) begin
			sr_sr[k] <= nxt;
		end
	end

	// ---------------- output register; round the root to nearest
	sr_t sr_last;
	assign sr_last = sr_sr[RB-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= sr_v_sr[RB-1];
		end
	end

	always_ff @(posedge clk) begin
		result.near_x   <= sr_last.res[0];
		result.near_y   <= sr_last.res[1];
		result.near_z   <= sr_last.res[2];
		result.distance <= vcp_pkg::DIST_W'(sr_last.root) +
				vcp_pkg::DIST_W'(sr_last.rem > (RB+1)'(sr_last.root));
		result.status   <= sr_last.status;
	end

endmodule

// ===== dv/tb_vertex_constraint_projector.sv =====
`timescale 1ns / 1ps

module tb_vertex_constraint_projector;

	localparam int WIDE_W    = 192;
	localparam int LATENCY   = 108;
	localparam int WDOG_MAX  = 5000;
	localparam int N_RANDOM  = 1030;

	typedef logic signed [WIDE_W-1:0] wide_t;

	typedef struct {
		vcp_pkg::in_item_t  req;
		bit                 typed;
		vcp_pkg::out_item_t want;
	} vec_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	vcp_pkg::in_item_t  item = '0;
	logic               busy;
	logic               done;
	vcp_pkg::out_item_t result;

	vcp_pkg::out_item_t expected_q[$];
	int                 errors = 0;
	int                 quiet_cycles = 0;
	int                 idle_pct = 38;
	vec_t               vectors[$];

	vertex_constraint_projector dut (
		.clk(clk), .arst_n(arst_n), .start(start), .item(item),
		.busy(busy), .done(done), .result(result)
	);

	always #5 clk = ~clk;

	function automatic wide_t div_round(wide_t num, wide_t den);
		wide_t mn, md, r;
		mn = num < 0 ? -num : num;
		md = den < 0 ? -den : den;
		r = (2 * mn + md) / (2 * md);
		return ((num < 0) != (den < 0)) ? -r : r;
	endfunction

	function automatic wide_t sqrt_round(wide_t s);
		wide_t r, c;
		r = 0;
		for (int i = 36; i >= 0; i--) begin
			c = r | (wide_t'(1) <<< i);
			if (c * c <= s)
				r = c;
		end
		if (s - r * r > r)
			r = r + 1;
		return r;
	endfunction

	function automatic vcp_pkg::out_item_t project_vertex(vcp_pkg::in_item_t it);
		wide_t              cf[6], pt[3], nr[3], dir[3], base[3], n, q, dd, sum;
		wide_t              hi, lo;
		logic [1:0]         st;
		bit                 sat;
		vcp_pkg::out_item_t o;
		cf[0] = wide_t'($signed(it.coef_a)); cf[1] = wide_t'($signed(it.coef_b));
		cf[2] = wide_t'($signed(it.coef_c)); cf[3] = wide_t'($signed(it.coef_d));
		cf[4] = wide_t'($signed(it.coef_e)); cf[5] = wide_t'($signed(it.coef_f));
		pt[0] = wide_t'($signed(it.point_x));
		pt[1] = wide_t'($signed(it.point_y));
		pt[2] = wide_t'($signed(it.point_z));
		hi = (wide_t'(1) <<< (vcp_pkg::COORD_W - 1)) - 1;
		lo = -(wide_t'(1) <<< (vcp_pkg::COORD_W - 1));
		st = vcp_pkg::STAT_OK;
		sat = 0;
		n = 0;
		q = 0;
		unique case (it.kind)
			vcp_pkg::KIND_FIXED: for (int i = 0; i < 3; i++) nr[i] = cf[i];
			vcp_pkg::KIND_LINE: begin
				for (int i = 0; i < 3; i++) begin
					dir[i] = cf[2*i];
					base[i] = cf[2*i+1];
					n += dir[i] * (pt[i] - base[i]);
					q += dir[i] * dir[i];
				end
			end
			vcp_pkg::KIND_PLANE: begin
				for (int i = 0; i < 3; i++) begin
					dir[i] = cf[i];
					base[i] = pt[i];
					n += cf[i] * pt[i];
					q += cf[i] * cf[i];
				end
				// projection moves against the signed plane offset
				n = -(n - (cf[3] <<< vcp_pkg::FRAC_BITS));
			end
			default: st = vcp_pkg::STAT_UNKNOWN;
		endcase
		if (st == vcp_pkg::STAT_OK && it.kind != vcp_pkg::KIND_FIXED && q == 0)
			st = vcp_pkg::STAT_ZERO;
		if (st != vcp_pkg::STAT_OK) begin
			o.near_x = it.point_x; o.near_y = it.point_y; o.near_z = it.point_z;
			o.distance = '0;
			o.status = st;
			return o;
		end
		if (it.kind != vcp_pkg::KIND_FIXED)
			for (int i = 0; i < 3; i++) nr[i] = base[i] + div_round(dir[i] * n, q);
		sum = 0;
		for (int i = 0; i < 3; i++) begin
			if (nr[i] > hi) begin nr[i] = hi; sat = 1; end
			if (nr[i] < lo) begin nr[i] = lo; sat = 1; end
			dd = pt[i] - nr[i];
			sum += dd * dd;
		end
		o.near_x = nr[0][vcp_pkg::COORD_W-1:0];
		o.near_y = nr[1][vcp_pkg::COORD_W-1:0];
		o.near_z = nr[2][vcp_pkg::COORD_W-1:0];
		o.distance = vcp_pkg::DIST_W'(sqrt_round(sum));
		o.status = sat ? vcp_pkg::STAT_SAT : vcp_pkg::STAT_OK;
		return o;
	endfunction

	function automatic logic [vcp_pkg::COORD_W-1:0] rand_coord();
		case ($urandom_range(0, 9))
			0, 1:    return $urandom();
			2:       return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
			3:       return $urandom_range(0, 3) - 1;
			default: return $signed($urandom_range(0, 32'h3ff_ffff)) - 32'sh1ff_ffff;
		endcase
	endfunction

	function automatic vcp_pkg::in_item_t rand_item();
		vcp_pkg::in_item_t it;
		it.kind = ($urandom_range(0, 19) == 0) ? vcp_pkg::KIND_UNKNOWN :
				2'($urandom_range(0, 2));
		it.coef_a = rand_coord(); it.coef_b = rand_coord(); it.coef_c = rand_coord();
		it.coef_d = rand_coord(); it.coef_e = rand_coord(); it.coef_f = rand_coord();
		it.point_x = rand_coord(); it.point_y = rand_coord(); it.point_z = rand_coord();
		// force a degenerate direction or normal now and then
		if ($urandom_range(0, 24) == 0) begin
			it.coef_a = '0;
			if (it.kind == vcp_pkg::KIND_LINE) it.coef_e = '0; else it.coef_b = '0;
			it.coef_c = '0;
		end
		return it;
	endfunction

	function automatic vcp_pkg::in_item_t mk(logic [1:0] k,
		logic [vcp_pkg::COORD_W-1:0] a, b, c, d, e, f,
		logic [vcp_pkg::COORD_W-1:0] x, y, z);
		vcp_pkg::in_item_t it;
		it = '{kind: k, coef_a: a, coef_b: b, coef_c: c, coef_d: d, coef_e: e,
			coef_f: f, point_x: x, point_y: y, point_z: z};
		return it;
	endfunction

	function automatic void add_row(vcp_pkg::in_item_t it, bit typed,
		vcp_pkg::out_item_t want);
		vec_t v;
		v.req = it; v.typed = typed; v.want = want;
		vectors.push_back(v);
	endfunction

	task automatic send_transaction(vcp_pkg::in_item_t it, vcp_pkg::out_item_t want);
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		item <= it;
		@(posedge clk);
		while (busy) @(posedge clk);
		expected_q.push_back(want);
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			vcp_pkg::out_item_t e;
			if (expected_q.size() == 0) begin
				$error("result with no transaction pending: %p", result);
				errors++;
			end else begin
				e = expected_q.pop_front();
				if (result.near_x !== e.near_x) begin
					$error("near_x exp %h got %h", e.near_x, result.near_x); errors++;
				end
				if (result.near_y !== e.near_y) begin
					$error("near_y exp %h got %h", e.near_y, result.near_y); errors++;
				end
				if (result.near_z !== e.near_z) begin
					$error("near_z exp %h got %h", e.near_z, result.near_z); errors++;
				end
				if (result.distance !== e.distance) begin
					$error("distance exp %h got %h", e.distance, result.distance); errors++;
				end
				if (result.status !== e.status) begin
					$error("status exp %0d got %0d", e.status, result.status); errors++;
				end
			end
		end
	end

	// watchdog: no traffic in either direction for too long
	always @(posedge clk) begin
		if ((start && !busy) || done)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WDOG_MAX) begin
			$display("tb_vertex_constraint_projector NOT OK");
			$finish;
		end
	end

	initial begin
		vcp_pkg::in_item_t           it;
		vcp_pkg::out_item_t          w;
		logic [vcp_pkg::COORD_W-1:0] mx, mn;
		mx = 32'h7fff_ffff;
		mn = 32'h8000_0000;

		// unknown kind echoes the vertex
		it = mk(vcp_pkg::KIND_UNKNOWN, mx, mn, 1, 2, 3, 4, 32'h1234_5678, mn, mx);
		add_row(it, 1, '{it.point_x, it.point_y, it.point_z, '0, vcp_pkg::STAT_UNKNOWN});
		// zero direction on a line, zero normal on a plane
		it = mk(vcp_pkg::KIND_LINE, 0, mx, 0, mn, 0, 5, 32'h0001_0000, 2, 3);
		add_row(it, 1, '{it.point_x, it.point_y, it.point_z, '0, vcp_pkg::STAT_ZERO});
		it = mk(vcp_pkg::KIND_PLANE, 0, 0, 0, mx, mn, mx, mn, mn, mn);
		add_row(it, 1, '{it.point_x, it.point_y, it.point_z, '0, vcp_pkg::STAT_ZERO});
		// fixed point equal to the vertex, then one at a distance of 5.0 from it
		it = mk(vcp_pkg::KIND_FIXED, mx, mn, 0, 9, 9, 9, mx, mn, 0);
		add_row(it, 1, '{mx, mn, 32'h0, '0, vcp_pkg::STAT_OK});
		it = mk(vcp_pkg::KIND_FIXED, 32'h0003_0000, 0, 0, 0, 0, 0, 0, 32'h0004_0000, 0);
		add_row(it, 1, '{32'h0003_0000, 32'h0, 32'h0, 34'h5_0000, vcp_pkg::STAT_OK});
		// extremes and saturation, checked by the predictor
		add_row(mk(vcp_pkg::KIND_FIXED, mn, mx, mn, 0, 0, 0, mx, mn, mx), 0, w);
		add_row(mk(vcp_pkg::KIND_LINE, mx, mx, mx, mx, mx, mx, mn, mn, mn), 0, w);
		add_row(mk(vcp_pkg::KIND_LINE, mn, mn, mn, mn, mn, mn, mx, mx, mx), 0, w);
		add_row(mk(vcp_pkg::KIND_LINE, 1, mx, 0, 0, 0, 0, mn, mx, mx), 0, w);
		add_row(mk(vcp_pkg::KIND_LINE, 32'h0001_0000, 0, 32'h0001_0000, 0, 0, 0,
			32'h0002_0000, 0, 32'h0005_0000), 0, w);
		add_row(mk(vcp_pkg::KIND_PLANE, mx, mx, mx, mn, 0, 0, mn, mn, mn), 0, w);
		add_row(mk(vcp_pkg::KIND_PLANE, mn, mn, mn, mx, 0, 0, mx, mx, mx), 0, w);
		add_row(mk(vcp_pkg::KIND_PLANE, 0, 0, 1, mx, 0, 0, mx, mn, mn), 0, w);
		add_row(mk(vcp_pkg::KIND_PLANE, 0, 0, 32'h0001_0000, 32'h0002_0000, 0, 0,
			32'h0001_0000, 32'h0001_0000, 32'h0007_0000), 0, w);
		add_row(mk(vcp_pkg::KIND_PLANE, 3, 7, mn, 1, 0, 0, 32'hffff_ffff, 1, 0), 0, w);
		for (int i = 0; i < N_RANDOM; i++)
			add_row(rand_item(), 0, w);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (vectors[i]) begin
			if (i == vectors.size() / 3) idle_pct = 55;
			if (i == 2 * vectors.size() / 3) idle_pct = 0;
			send_transaction(vectors[i].req,
				vectors[i].typed ? vectors[i].want : project_vertex(vectors[i].req));
		end
		start <= 1'b0;

		while (expected_q.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		if (errors == 0)
			$display("tb_vertex_constraint_projector OK");
		else
			$display("tb_vertex_constraint_projector NOT OK");
		$finish;
	end

endmodule

// ===== sim.f =====
src/vcp_pkg.sv
src/vertex_constraint_projector.sv
dv/tb_vertex_constraint_projector.sv
